// ----- rtl/softmax_normalize_unit_defines.svh -----
`ifndef SOFTMAX_NORMALIZE_UNIT_DEFINES_SVH
`define SOFTMAX_NORMALIZE_UNIT_DEFINES_SVH
// assertion helpers
`define SMN_ASSERT_IMPL(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |-> (c)) \
    else $error("lbl failed");
`define SMN_ASSERT_NEXT(lbl, clk_s, rst_s, a, c) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |=> (c)) \
    else $error("lbl failed");
`endif

// ----- rtl/smn_pkg.sv -----
package smn_pkg;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned PROB_W  = 16;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned CFG_W   = 7;
  localparam logic [15:0] LOG2E_Q15 = 16'd47274;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_EXP   = 6'b000010,
    ST_DIVI  = 6'b000100,
    ST_DIVR  = 6'b001000,
    ST_OUT   = 6'b010000,
    ST_ERR   = 6'b100000
  } state_t;

  function automatic logic [16:0] pow2_frac(input logic [4:0] i);
    case (i)
      5'd0:  pow2_frac = 17'd65536;
      5'd1:  pow2_frac = 17'd62757;
      5'd2:  pow2_frac = 17'd60097;
      5'd3:  pow2_frac = 17'd57549;
      5'd4:  pow2_frac = 17'd55109;
      5'd5:  pow2_frac = 17'd52773;
      5'd6:  pow2_frac = 17'd50535;
      5'd7:  pow2_frac = 17'd48392;
      5'd8:  pow2_frac = 17'd46341;
      5'd9:  pow2_frac = 17'd44376;
      5'd10: pow2_frac = 17'd42494;
      5'd11: pow2_frac = 17'd40693;
      5'd12: pow2_frac = 17'd38968;
      5'd13: pow2_frac = 17'd37315;
      5'd14: pow2_frac = 17'd35734;
      5'd15: pow2_frac = 17'd34219;
      5'd16: pow2_frac = 17'd32768;
      default: pow2_frac = 17'd0;
    endcase
  endfunction
endpackage

// ----- rtl/softmax_normalize_unit.sv -----
// Softmax over one vector of Q8.8 scores, streamed in with tlast on the final
// beat; cfg_wdata sets the expected vector length (1..MAX_LEN, reset 64).
// In load a score is taken whenever in_tvalid is high. On tlast the block
// stops accepting; for a good length it reads the score memory to form
// exp(score - max). Each element goes through a memory read, a registered
// multiply, then the table step. The values go into a saturating 24-bit sum.
// The block then recomputes each exp and divides it by the sum in a shared
// restoring divider, one quotient bit per cycle. Each result passes through
// the exp steps, the divider setup and the 17-bit quotient before its beat
// is offered in the output state, where an out_tready stall holds it. A
// wrong-length vector gives a single length_error beat in the cycle after tlast.
module softmax_normalize_unit #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // score
  input  logic        in_tlast,   // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // probability
  output logic        out_tlast,  // last_out
  output logic        out_tuser   // length_error
);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 2);

  smn_pkg::state_t state_r, state_nxt;
  logic [6:0]        vlen_r;
  logic [CW-1:0]     cnt_r;
  logic signed [15:0] max_r;
  logic [23:0]       sum_r;
  logic [AW-1:0]     idx_r;
  logic [1:0]        ph_r;
  logic [1:0]        phase_r;  // 0 = sum pass, 1 = divide pass
  logic [15:0]       mem [MAX_LEN];
  logic signed [15:0] rd_r;
  logic [31:0]       prod_r;
  logic [16:0]       e_r;
  logic [24:0]       rem_r;
  logic [16:0]       quo_r;
  logic [4:0]        bit_r;

  wire in_acc  = in_tvalid && in_tready;
  wire out_acc = out_tvalid && out_tready;
  assign in_tready  = state_r == smn_pkg::ST_LOAD;
  assign out_tvalid = state_r == smn_pkg::ST_OUT || state_r == smn_pkg::ST_ERR;

  always_ff @(posedge clk) begin
    if (in_acc && cnt_r < CW'(MAX_LEN)) mem[cnt_r[AW-1:0]] <= in_tdata;
    rd_r <= mem[idx_r];
  end

  wire [CW-1:0] cnt_inc = (cnt_r <= CW'(MAX_LEN)) ? cnt_r + 1'b1 : cnt_r;
  wire len_bad = vlen_r == 7'd0 || 32'(vlen_r) > MAX_LEN
                 || 32'(cnt_inc) != 32'(vlen_r);

  // exp stage: m*log2e registered in prod_r
  wire [15:0] m   = 16'(max_r - rd_r);
  wire [16:0] t   = prod_r[31:15];
  wire [8:0]  n   = t[16:8];
  wire [16:0] tk  = smn_pkg::pow2_frac({1'b0, t[7:4]});
  wire [16:0] tk1 = smn_pkg::pow2_frac(5'({1'b0, t[7:4]} + 5'd1));
  wire [20:0] dr  = 21'(tk - tk1) * 21'(t[3:0]);
  wire [16:0] v   = tk - 17'(dr >> 4);
  wire [16:0] e   = (n >= 9'd17) ? 17'd0 : v >> n[4:0];
  wire [24:0] sum_add = 25'(sum_r) + 25'(e);
  // first step takes the integer bit, the rest shift one bit in
  wire [25:0] trial = (bit_r == 5'd16) ? {1'b0, rem_r} : {rem_r, 1'b0};
  wire last_el = 32'(idx_r) + 1 == 32'(vlen_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      smn_pkg::ST_LOAD: if (in_acc && in_tlast)
        state_nxt = len_bad ? smn_pkg::ST_ERR : smn_pkg::ST_EXP;
      smn_pkg::ST_EXP: if (ph_r == 2'd2 && phase_r == 2'd1) state_nxt = smn_pkg::ST_DIVI;
      smn_pkg::ST_DIVI: state_nxt = smn_pkg::ST_DIVR;
      smn_pkg::ST_DIVR: if (bit_r == 5'd0) state_nxt = smn_pkg::ST_OUT;
      smn_pkg::ST_OUT: if (out_acc)
        state_nxt = last_el ? smn_pkg::ST_LOAD : smn_pkg::ST_EXP;
      smn_pkg::ST_ERR: if (out_acc) state_nxt = smn_pkg::ST_LOAD;
      default: state_nxt = smn_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smn_pkg::ST_LOAD;
      vlen_r  <= 7'd64;
      cnt_r   <= '0;
      max_r   <= 16'sh8000;
      sum_r   <= '0;
      idx_r   <= '0;
      ph_r    <= '0;
      phase_r <= '0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) vlen_r <= cfg_wdata;
      case (state_r)
        smn_pkg::ST_LOAD: if (in_acc) begin
          cnt_r <= cnt_inc;
          if ($signed(in_tdata) > max_r) max_r <= $signed(in_tdata);
          idx_r <= '0; ph_r <= '0; phase_r <= '0; sum_r <= '0;
          if (in_tlast) cnt_r <= '0;
        end
        smn_pkg::ST_EXP: begin
          ph_r <= (ph_r == 2'd2) ? 2'd0 : ph_r + 2'd1;
          if (ph_r == 2'd2 && phase_r == 2'd0) begin
            sum_r <= sum_add > 25'hFFFFFF ? 24'hFFFFFF : sum_add[23:0];
            if (last_el) begin idx_r <= '0; phase_r <= 2'd1; end
            else idx_r <= idx_r + 1'b1;
          end
        end
        smn_pkg::ST_DIVI: bit_r <= 5'd16;
        smn_pkg::ST_DIVR: bit_r <= bit_r - 5'd1;
        smn_pkg::ST_OUT: if (out_acc) begin
          idx_r <= idx_r + 1'b1;
          if (last_el) begin max_r <= 16'sh8000; sum_r <= '0; end
        end
        smn_pkg::ST_ERR: if (out_acc) max_r <= 16'sh8000;
        default: ;
      endcase
    end
  end

  // datapath regs
  always_ff @(posedge clk) begin
    prod_r <= 32'(m) * 32'(smn_pkg::LOG2E_Q15);
    if (state_r == smn_pkg::ST_EXP && ph_r == 2'd2) e_r <= e;
    if (state_r == smn_pkg::ST_DIVI) begin
      rem_r <= {8'd0, e_r};
      quo_r <= '0;
    end else if (state_r == smn_pkg::ST_DIVR) begin
      if (trial >= 26'(sum_r)) begin
        rem_r <= 25'(trial - 26'(sum_r));
        quo_r <= {quo_r[15:0], 1'b1};
      end else begin
        rem_r <= trial[24:0];
        quo_r <= {quo_r[15:0], 1'b0};
      end
    end
  end

  assign out_tdata = (state_r == smn_pkg::ST_ERR) ? 16'd0
                   : (quo_r[16] ? 16'hFFFF : quo_r[15:0]);
  assign out_tlast = (state_r == smn_pkg::ST_ERR) || last_el;
  assign out_tuser = state_r == smn_pkg::ST_ERR;
endmodule

// ----- rtl/smn_checker.sv -----
`include "softmax_normalize_unit_defines.svh"
module smn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);
  `SMN_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)
  `SMN_ASSERT_IMPL(a_err_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  `SMN_ASSERT_IMPL(a_err_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 16'd0)
  `SMN_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
endmodule

bind softmax_normalize_unit smn_checker u_smn_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast), .out_tuser(out_tuser)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  typedef struct packed {
    logic [15:0] prob;
    logic        last;
    logic        err;
  } prob_beat_t;

  prob_beat_t  prob_q[$];
  logic signed [15:0] vec_scores[MAX_LEN];
  int unsigned vec_count;
  logic signed [15:0] vec_max;
  int unsigned exp_len;
  int          fail_count = 0;
  int          gap_max = 3;
  bit          stall_on = 1'b1;

  localparam logic [16:0] POW2_TBL[17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773, 17'd50535,
    17'd48392, 17'd46341, 17'd44376, 17'd42494, 17'd40693, 17'd38968, 17'd37315,
    17'd35734, 17'd34219, 17'd32768
  };

  softmax_normalize_unit #(.MAX_LEN(MAX_LEN)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] exp_q16(logic signed [15:0] s, logic signed [15:0] mx);
    logic [63:0] m, t;
    logic [31:0] n, k, r, v;
    m = 64'(32'(int'(mx) - int'(s)));
    t = (m * 64'd47274) >> 15;
    n = 32'(t >> 8);
    k = 32'((t >> 4) & 64'hF);
    r = 32'(t & 64'hF);
    if (n >= 17) return 32'd0;
    v = 32'(POW2_TBL[k]) - (((32'(POW2_TBL[k]) - 32'(POW2_TBL[k + 1])) * r) >> 4);
    return v >> n;
  endfunction

  task automatic predict_score(logic signed [15:0] s, bit last);
    logic [31:0] sum;
    logic [63:0] p;
    prob_beat_t b;
    if (vec_count < MAX_LEN) vec_scores[vec_count] = s;
    if (vec_count <= MAX_LEN) vec_count++;
    if (s > vec_max) vec_max = s;
    if (!last) return;
    if (exp_len == 0 || exp_len > MAX_LEN || vec_count != exp_len) begin
      b.prob = '0; b.last = 1'b1; b.err = 1'b1;
      prob_q = {prob_q, b};
    end else begin
      sum = 0;
      for (int i = 0; i < vec_count; i++) begin
        sum += exp_q16(vec_scores[i], vec_max);
        if (sum > 32'hFFFFFF) sum = 32'hFFFFFF;
      end
      for (int i = 0; i < vec_count; i++) begin
        p = (64'(exp_q16(vec_scores[i], vec_max)) << 16) / 64'(sum);
        if (p > 65535) p = 65535;
        b.prob = p[15:0]; b.last = (i + 1 == vec_count); b.err = 1'b0;
        prob_q = {prob_q, b};
      end
    end
    vec_count = 0;
    vec_max = -16'sd32768;
  endtask

  task automatic send_score(logic signed [15:0] s, bit last);
    int gap;
    gap = (gap_max > 0 && $urandom_range(3) == 0) ? $urandom_range(gap_max) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_score(s, last);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (prob_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_len(int unsigned len);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= 7'(len);
    @(posedge clk);
    cfg_we    <= 1'b0;
    exp_len = len & 7'h7F;
  endtask

  task automatic send_vector(int unsigned len, int mode);
    logic signed [15:0] s;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: s = 16'($urandom);
        1: s = 16'($urandom_range(1024)) - 16'sd512;
        default: s = 16'sd0;
      endcase
      send_score(s, i == len - 1);
    end
  endtask

  task automatic test_directed();
    write_len(4);
    send_score(16'sh7FFF, 0); send_score(-16'sd32768, 0);
    send_score(16'sh0000, 0); send_score(16'shFFFF, 1);
    send_vector(4, 2);
    send_vector(3, 1);
    write_len(1);
    send_score(-16'sd32768, 1);
    send_score(16'sh5555, 1);
    send_vector(2, 0);
  endtask

  task automatic test_lengths();
    write_len(64);
    send_vector(64, 1);
    write_len(0);
    send_vector(1, 0);
    write_len(65);
    send_vector(1, 0);
    write_len(64);
    send_vector(65, 0);
    write_len(2);
    send_score(16'shAAAA, 0); send_score(16'sh5555, 1);
  endtask

  task automatic test_random();
    int unsigned len;
    int items = 0;
    while (items < 16) begin
      if ($urandom_range(3) == 0) write_len($urandom_range(8, 1));
      if (stall_on && $urandom_range(5) == 0) gap_max = $urandom_range(0, 6);
      len = ($urandom_range(4) == 0) ? $urandom_range(exp_len + 2, 1) : exp_len;
      if (len == 0) len = 1;
      send_vector(len, $urandom_range(1));
      items += len;
    end
  endtask

  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if ((cyc % 97) < 30) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(2) != 0);
    end
  end

  always @(posedge clk) begin
    prob_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (prob_q.size() == 0) begin
        $error("unexpected beat prob=%0d", out_tdata);
        fail_count++;
      end else begin
        e = prob_q.pop_front();
        if (out_tdata !== e.prob) begin
          $error("probability expected %0d actual %0d", e.prob, out_tdata); fail_count++;
        end
        if (out_tlast !== e.last) begin
          $error("last_out expected %0d actual %0d", e.last, out_tlast); fail_count++;
        end
        if (out_tuser !== e.err) begin
          $error("length_error expected %0d actual %0d", e.err, out_tuser); fail_count++;
        end
      end
    end
  end

  initial begin
    exp_len = 64;
    vec_count = 0;
    vec_max = -16'sd32768;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_lengths();
    test_random();
    wait_drain();
    if (fail_count == 0) $display("softmax_normalize_unit test passed");
    else $display("softmax_normalize_unit test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("softmax_normalize_unit test failed");
    $finish;
  end
endmodule
